### rtl/buddy_block_allocator_defines.svh
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bba_pkg.sv
package bba_pkg;

   localparam int BLOCKS_DEFAULT   = 128;

   localparam int OPERATION_W      = 1;
   localparam int REQUEST_BLOCKS_W = 8;
   localparam int FREE_BLOCK_W     = 7;
   localparam int BLOCK_OFFSET_W   = 7;
   localparam int WANT_W           = REQUEST_BLOCKS_W + 1;

   localparam logic [OPERATION_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SELF,
      RD_KIDS,
      RD_SIBS
   } rd_kind_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZERO,
      WR_SPAN,
      WR_MAX,
      WR_MERGE
   } wr_kind_type;

   typedef enum logic [1:0] {
      MOVE_HOLD,
      MOVE_DOWN,
      MOVE_UP
   } move_type;

   typedef struct packed {
      logic        load;
      logic        clear;
      rd_kind_type rd;
      move_type    move;
      wr_kind_type wr;
      logic        rsp_load;
      logic        rsp_fail;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic no_fit;
      logic at_target;
      logic desc_last;
      logic is_root;
      logic node_zero;
      logic blk_bad;
   } status_type;

endpackage

### rtl/bba_if.sv
interface bba_req_if;
   import bba_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OPERATION_W-1:0]      operation;
   logic [REQUEST_BLOCKS_W-1:0] request_blocks;
   logic [FREE_BLOCK_W-1:0]     free_block;

   modport source (output valid, output operation, output request_blocks,
                   output free_block, input ready);
   modport sink   (input valid, input operation, input request_blocks,
                   input free_block, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [BLOCK_OFFSET_W-1:0] block_offset;
   logic                      failed;

   modport source (output valid, output block_offset, output failed, input ready);
   modport sink   (input valid, input block_offset, input failed, output ready);
endinterface

### rtl/buddy_block_allocator.sv
// allocate: a new request is taken as soon as the result is registered
// free: no result; one request in flight at a time
// each level of an update climb costs a read and a write on the single-write node memory
// reset is synchronous; afterwards a clearing pass loads every node with its subtree size,
// and no request is taken until it ends
module buddy_block_allocator #(
   parameter int BLOCKS = bba_pkg::BLOCKS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bba_req_if.sink   req_ch,
   bba_rsp_if.source rsp_ch
);
   import bba_pkg::*;

   cmd_type    cmd;
   status_type status;

   bba_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   bba_datapath #(
      .BLOCKS (BLOCKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_ch.operation),
      .req_request_blocks (req_ch.request_blocks),
      .req_free_block     (req_ch.free_block),
      .status             (status),
      .rsp_block_offset   (rsp_ch.block_offset),
      .rsp_failed         (rsp_ch.failed)
   );

endmodule

### rtl/bba_controller.sv
module bba_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bba_pkg::OPERATION_W-1:0]   req_operation,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  bba_pkg::status_type               status,
   output bba_pkg::cmd_type                  cmd
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_ROOT,
      S_A_CHECK,
      S_A_FETCH,
      S_A_DESC,
      S_A_MARK,
      S_A_UFETCH,
      S_A_UWRITE,
      S_DONE_OK,
      S_DONE_FAIL,
      S_F_READ,
      S_F_TEST,
      S_F_UFETCH,
      S_F_UWRITE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '{load: 1'b0, clear: 1'b0, rd: RD_NONE, move: MOVE_HOLD,
                       wr: WR_NONE, rsp_load: 1'b0, rsp_fail: 1'b0};
      unique case (state_ff) inside
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_operation == OP_ALLOC) ? S_A_ROOT : S_F_READ;
            end
         end
         S_A_ROOT: begin
            cmd.rd   = RD_SELF;
            state_in = S_A_CHECK;
         end
         S_A_CHECK: begin
            if (status.no_fit)         state_in = S_DONE_FAIL;
            else if (status.at_target) state_in = S_A_MARK;
            else                       state_in = S_A_FETCH;
         end
         S_A_FETCH: begin
            cmd.rd   = RD_KIDS;
            state_in = S_A_DESC;
         end
         S_A_DESC: begin
            cmd.move = MOVE_DOWN;
            state_in = status.desc_last ? S_A_MARK : S_A_FETCH;
         end
         S_A_MARK: begin
            cmd.wr   = WR_ZERO;
            state_in = status.is_root ? S_DONE_OK : S_A_UFETCH;
         end
         S_A_UFETCH: begin
            cmd.rd   = RD_SIBS;
            cmd.move = MOVE_UP;
            state_in = S_A_UWRITE;
         end
         S_A_UWRITE: begin
            cmd.wr   = WR_MAX;
            state_in = status.is_root ? S_DONE_OK : S_A_UFETCH;
         end
         S_DONE_OK, S_DONE_FAIL: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_fail = (state_ff == S_DONE_FAIL);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_F_READ: begin
            if (status.blk_bad) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd   = RD_SELF;
               state_in = S_F_TEST;
            end
         end
         S_F_TEST: begin
            if (!status.node_zero) begin
               if (status.is_root) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.move = MOVE_UP;
                  state_in = S_F_READ;
               end
            end else begin
               cmd.wr   = WR_SPAN;
               state_in = status.is_root ? S_IDLE : S_F_UFETCH;
            end
         end
         S_F_UFETCH: begin
            cmd.rd   = RD_SIBS;
            cmd.move = MOVE_UP;
            state_in = S_F_UWRITE;
         end
         S_F_UWRITE: begin
            cmd.wr   = WR_MERGE;
            state_in = status.is_root ? S_IDLE : S_F_UFETCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/bba_datapath.sv
module bba_datapath #(
   parameter int BLOCKS = bba_pkg::BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bba_pkg::cmd_type                    cmd,
   input  logic [bba_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [bba_pkg::REQUEST_BLOCKS_W-1:0] req_request_blocks,
   input  logic [bba_pkg::FREE_BLOCK_W-1:0]    req_free_block,
   output bba_pkg::status_type                 status,
   output logic [bba_pkg::BLOCK_OFFSET_W-1:0]  rsp_block_offset,
   output logic                                rsp_failed
);
   import bba_pkg::*;

   localparam int LOG        = $clog2(BLOCKS);
   localparam int VAL_W      = LOG + 1;
   localparam int NODE_W     = LOG + 1;
   localparam int NODE_SLOTS = 2 * BLOCKS;
   localparam int NODE_LAST  = 2 * BLOCKS - 1;
   localparam int OFS_W      = (LOG > BLOCK_OFFSET_W) ? LOG : BLOCK_OFFSET_W;
   localparam int CMP_W      = (VAL_W > WANT_W) ? VAL_W : WANT_W;
   localparam int BLK_W      = (NODE_W > FREE_BLOCK_W) ? NODE_W : FREE_BLOCK_W;

   function automatic logic [WANT_W-1:0] round_pow2(
      input logic [REQUEST_BLOCKS_W-1:0] n
   );
      logic [REQUEST_BLOCKS_W-1:0] m;
      logic [WANT_W-1:0]           p;
      m = (n == '0) ? '0 : n - 1'b1;
      p = WANT_W'(1);
      for (int i = 0; i < REQUEST_BLOCKS_W; i++) begin
         if (m[i]) p = WANT_W'(2) << i;
      end
      return p;
   endfunction

   logic [VAL_W-1:0]  mem [NODE_SLOTS];

   logic [NODE_W-1:0] node_ff, node_in;
   logic [VAL_W-1:0]  span_ff, span_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic              blk_bad_ff, blk_bad_in;
   logic [NODE_W-1:0] clr_idx_ff, clr_idx_in;
   logic [VAL_W-1:0]  clr_span_ff, clr_span_in;
   logic [VAL_W-1:0]  qa_ff, qb_ff;
   logic [BLOCK_OFFSET_W-1:0] rsp_offset_ff;
   logic              rsp_failed_ff;

   logic [VAL_W-1:0]  child_span;
   logic [VAL_W-1:0]  larger_val;
   logic [VAL_W:0]    pair_sum;
   logic [NODE_W-1:0] kids_base, sibs_base;
   logic [NODE_W-1:0] rd_addr_a, rd_addr_b, wr_addr, clr_next;
   logic [VAL_W-1:0]  wr_data;
   logic              rd_en, wr_en;
   logic              left_fit, right_fit, go_right;
   logic [BLK_W-1:0]  blk_ext;

   assign child_span = span_ff >> 1;
   assign larger_val = (qa_ff > qb_ff) ? qa_ff : qb_ff;
   assign pair_sum   = {1'b0, qa_ff} + {1'b0, qb_ff};
   assign kids_base  = {node_ff[NODE_W-2:0], 1'b0};
   assign sibs_base  = {node_ff[NODE_W-1:1], 1'b0};
   assign left_fit   = CMP_W'(qa_ff) >= CMP_W'(want_ff);
   assign right_fit  = CMP_W'(qb_ff) >= CMP_W'(want_ff);
   assign go_right   = (qa_ff <= qb_ff) ? !left_fit : right_fit;
   assign blk_ext    = BLK_W'(req_free_block);
   assign clr_next   = clr_idx_ff + NODE_W'(1);

   always_comb begin
      rd_en     = 1'b1;
      rd_addr_a = node_ff;
      rd_addr_b = node_ff;
      unique case (cmd.rd)
         RD_NONE: rd_en = 1'b0;
         RD_SELF: rd_addr_a = node_ff;
         RD_KIDS: begin
            rd_addr_a = kids_base;
            rd_addr_b = kids_base | NODE_W'(1);
         end
         RD_SIBS: begin
            rd_addr_a = sibs_base;
            rd_addr_b = sibs_base | NODE_W'(1);
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = node_ff;
      wr_data = '0;
      if (cmd.clear) begin
         wr_addr = clr_idx_ff;
         wr_data = clr_span_ff;
      end else begin
         unique case (cmd.wr)
            WR_NONE:  wr_en = 1'b0;
            WR_ZERO:  wr_data = '0;
            WR_SPAN:  wr_data = span_ff;
            WR_MAX:   wr_data = larger_val;
            WR_MERGE: wr_data = (pair_sum == {1'b0, span_ff}) ? span_ff : larger_val;
            default:  wr_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      node_in     = node_ff;
      span_in     = span_ff;
      offset_in   = offset_ff;
      want_in     = want_ff;
      blk_bad_in  = blk_bad_ff;
      clr_idx_in  = clr_idx_ff;
      clr_span_in = clr_span_ff;
      if (cmd.clear) begin
         clr_idx_in = clr_next;
         if ((clr_next & clr_idx_ff) == '0) clr_span_in = clr_span_ff >> 1;
      end
      if (cmd.load) begin
         if (req_operation == OP_ALLOC) begin
            node_in   = NODE_W'(1);
            span_in   = VAL_W'(BLOCKS);
            offset_in = '0;
            want_in   = round_pow2(req_request_blocks);
         end else begin
            node_in    = NODE_W'(BLOCKS) + NODE_W'(blk_ext);
            span_in    = VAL_W'(1);
            blk_bad_in = blk_ext >= BLK_W'(BLOCKS);
         end
      end
      unique case (cmd.move)
         MOVE_HOLD: ;
         MOVE_DOWN: begin
            node_in = go_right ? (kids_base | NODE_W'(1)) : kids_base;
            span_in = child_span;
            if (go_right) offset_in = offset_ff + OFS_W'(child_span);
         end
         MOVE_UP: begin
            node_in = node_ff >> 1;
            span_in = span_ff << 1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         qa_ff <= mem[rd_addr_a];
         qb_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= NODE_W'(1);
         clr_span_ff <= VAL_W'(BLOCKS);
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clr_span_ff <= clr_span_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      span_ff    <= span_in;
      offset_ff  <= offset_in;
      want_ff    <= want_in;
      blk_bad_ff <= blk_bad_in;
      if (cmd.rsp_load) begin
         rsp_failed_ff <= cmd.rsp_fail;
         rsp_offset_ff <= cmd.rsp_fail ? '0 : offset_ff[BLOCK_OFFSET_W-1:0];
      end
   end

   assign status.clear_last = (clr_idx_ff == NODE_W'(NODE_LAST));
   assign status.no_fit     = CMP_W'(qa_ff) < CMP_W'(want_ff);
   assign status.at_target  = (CMP_W'(span_ff) == CMP_W'(want_ff)) ||
                              (span_ff == VAL_W'(1));
   assign status.desc_last  = (CMP_W'(child_span) == CMP_W'(want_ff)) ||
                              (child_span == VAL_W'(1));
   assign status.is_root    = (node_ff == NODE_W'(1));
   assign status.node_zero  = (qa_ff == '0);
   assign status.blk_bad    = blk_bad_ff;

   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_failed       = rsp_failed_ff;

endmodule

### rtl/bba_checker.sv
`include "buddy_block_allocator_defines.svh"

module bba_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bba_pkg::BLOCK_OFFSET_W-1:0]  rsp_block_offset,
   input logic                                rsp_failed
);
   import bba_pkg::*;

   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_block_offset) && $stable(rsp_failed),
      "result changed while stalled")
   `BBA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_failed,
      rsp_block_offset == '0, "failed result carries a nonzero offset")
   `BBA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready,
      !req_ready, "request taken while previous one still in progress")
   `BBA_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid),
      !$past(req_ready), "result appeared without a request in progress")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_block_offset (rsp_ch.block_offset),
   .rsp_failed       (rsp_ch.failed)
);

### test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bba_pkg::*;

   localparam int NBLOCKS     = BLOCKS_DEFAULT;
   localparam int NODES       = 2 * NBLOCKS - 1;
   localparam int RANDOM_ITEMS = 1800;
   localparam int TAIL_CYCLES = 4 * $clog2(NBLOCKS) + 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [BLOCK_OFFSET_W-1:0] block_offset;
      logic                      failed;
   } grant_type;

   typedef struct {
      int first;
      int span;
   } region_type;

   class allocator_scoreboard_type;
      int          run_len[NODES];
      grant_type   grants_due[$];
      region_type  live[$];
      int          errors;
      int          allocs_ok;
      int          allocs_failed;
      int          frees;

      function new();
         int span;
         span = NBLOCKS << 1;
         for (int i = 0; i < NODES; i++) begin
            if (((i + 1) & i) == 0) span = span >> 1;
            run_len[i] = span;
         end
      endfunction

      function void predict_alloc(logic [REQUEST_BLOCKS_W-1:0] nblk);
         int want, node, span, lv, rv, first;
         grant_type g;
         want = 1;
         while (want < ((nblk == 0) ? 1 : int'(nblk))) want = want << 1;
         if (run_len[0] < want) begin
            g.block_offset = '0;
            g.failed = 1'b1;
            allocs_failed++;
         end else begin
            node = 0;
            span = NBLOCKS;
            while (span != want && span > 1) begin
               lv = run_len[2 * node + 1];
               rv = run_len[2 * node + 2];
               if (lv <= rv) node = (lv >= want) ? 2 * node + 1 : 2 * node + 2;
               else node = (rv >= want) ? 2 * node + 2 : 2 * node + 1;
               span = span >> 1;
            end
            run_len[node] = 0;
            first = (node + 1) * span - NBLOCKS;
            while (node != 0) begin
               node = (node + 1) / 2 - 1;
               lv = run_len[2 * node + 1];
               rv = run_len[2 * node + 2];
               run_len[node] = (lv > rv) ? lv : rv;
            end
            g.block_offset = first[BLOCK_OFFSET_W-1:0];
            g.failed = 1'b0;
            live.push_back('{first: first, span: span});
            allocs_ok++;
         end
         grants_due.push_back(g);
      endfunction

      function void release_block(logic [FREE_BLOCK_W-1:0] blk);
         int node, span, lv, rv;
         frees++;
         for (int i = 0; i < live.size(); i++) begin
            if (int'(blk) >= live[i].first && int'(blk) < live[i].first + live[i].span) begin
               live.delete(i);
               break;
            end
         end
         if (int'(blk) >= NBLOCKS) return;
         node = int'(blk) + NBLOCKS - 1;
         span = 1;
         while (run_len[node] != 0) begin
            span = span << 1;
            if (node == 0) return;
            node = (node + 1) / 2 - 1;
         end
         run_len[node] = span;
         while (node != 0) begin
            node = (node + 1) / 2 - 1;
            span = span << 1;
            lv = run_len[2 * node + 1];
            rv = run_len[2 * node + 2];
            if (lv + rv == span) run_len[node] = span;
            else run_len[node] = (lv > rv) ? lv : rv;
         end
      endfunction

      function void note_request(logic [OPERATION_W-1:0] op,
                                 logic [REQUEST_BLOCKS_W-1:0] nblk,
                                 logic [FREE_BLOCK_W-1:0] blk);
         if (op == OP_ALLOC) predict_alloc(nblk);
         else release_block(blk);
      endfunction

      function void check_result(logic [BLOCK_OFFSET_W-1:0] offset, logic failed);
         grant_type g;
         if (grants_due.size() == 0) begin
            $display("%0t: unexpected result offset %0d failed %0b", $time, offset, failed);
            errors++;
            return;
         end
         g = grants_due.pop_front();
         if (offset !== g.block_offset) begin
            $display("%0t: block_offset expected %0d actual %0d", $time,
                     g.block_offset, offset);
            errors++;
         end
         if (failed !== g.failed) begin
            $display("%0t: failed expected %0b actual %0b", $time, g.failed, failed);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   gap_pct;
   int   stall_pct;
   int   cycles;

   bba_req_if req_bus();
   bba_rsp_if rsp_bus();

   allocator_scoreboard_type sb = new();

   buddy_block_allocator #(.BLOCKS(NBLOCKS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.block_offset, rsp_bus.failed);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_item(input logic [OPERATION_W-1:0] op,
                            input logic [REQUEST_BLOCKS_W-1:0] nblk,
                            input logic [FREE_BLOCK_W-1:0] blk);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= op;
      req_bus.request_blocks <= nblk;
      req_bus.free_block     <= blk;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op, nblk, blk);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.grants_due.size() != 0);
   endtask

   function automatic void pick_item(output logic [OPERATION_W-1:0] op,
                                     output logic [REQUEST_BLOCKS_W-1:0] nblk,
                                     output logic [FREE_BLOCK_W-1:0] blk);
      int dice, k, pos;
      dice = $urandom_range(99);
      nblk = REQUEST_BLOCKS_W'($urandom);
      blk  = FREE_BLOCK_W'($urandom);
      if (sb.live.size() == 0 || dice < 55) begin
         op = OP_ALLOC;
         dice = $urandom_range(99);
         if (dice < 60) nblk = REQUEST_BLOCKS_W'($urandom_range(8));
         else if (dice < 85) nblk = REQUEST_BLOCKS_W'($urandom_range(32, 9));
         else if (dice < 95) nblk = REQUEST_BLOCKS_W'($urandom_range(128, 33));
         else nblk = REQUEST_BLOCKS_W'($urandom_range(255, 129));
      end else begin
         op = OP_FREE;
         if (dice < 95) begin
            k = $urandom_range(sb.live.size() - 1);
            pos = sb.live[k].first;
            if ($urandom_range(3) == 0)
               pos = pos + int'($urandom_range(sb.live[k].span - 1));
            blk = FREE_BLOCK_W'(pos);
         end
      end
   endfunction

   task automatic run_random(input int count);
      logic [OPERATION_W-1:0]      op;
      logic [REQUEST_BLOCKS_W-1:0] nblk;
      logic [FREE_BLOCK_W-1:0]     blk;
      for (int i = 0; i < count; i++) begin
         pick_item(op, nblk, blk);
         send_item(op, nblk, blk);
      end
   endtask

   initial begin
      reset = 1'b1;
      gap_pct = 0;
      stall_pct = 0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ALLOC;
      req_bus.request_blocks = '0;
      req_bus.free_block = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: whole pool, full pool, inner-block free, oversize and zero requests
      send_item(OP_ALLOC, 8'd128, 7'd0);
      send_item(OP_ALLOC, 8'd1, 7'd0);
      send_item(OP_FREE, 8'd0, 7'd77);
      send_item(OP_FREE, 8'd0, 7'd5);
      send_item(OP_ALLOC, 8'd255, 7'd127);
      send_item(OP_ALLOC, 8'd129, 7'd0);
      send_item(OP_ALLOC, 8'd0, 7'd0);
      send_item(OP_ALLOC, 8'd1, 7'd0);
      send_item(OP_ALLOC, 8'd3, 7'd0);
      send_item(OP_ALLOC, 8'd64, 7'd0);
      send_item(OP_ALLOC, 8'd33, 7'd0);
      send_item(OP_ALLOC, 8'd32, 7'd0);
      send_item(OP_FREE, 8'd255, 7'd127);
      send_item(OP_FREE, 8'd0, 7'd1);
      send_item(OP_FREE, 8'd0, 7'd0);
      send_item(OP_FREE, 8'd0, 7'd6);
      send_item(OP_FREE, 8'd0, 7'd40);
      send_item(OP_ALLOC, 8'd127, 7'd0);
      send_item(OP_FREE, 8'd0, 7'd0);
      send_item(OP_ALLOC, 8'd2, 7'd0);
      send_item(OP_ALLOC, 8'd16, 7'd0);
      send_item(OP_ALLOC, 8'd85, 7'd0);
      drain();

      // no idling
      run_random(RANDOM_ITEMS / 4);
      // sender pauses until every outstanding result is back
      drain();
      gap_pct = 63;
      stall_pct = 0;
      run_random(RANDOM_ITEMS / 4);
      drain();
      gap_pct = 0;
      stall_pct = 63;
      run_random(RANDOM_ITEMS / 4);
      drain();
      gap_pct = 8;
      stall_pct = 8;
      run_random(RANDOM_ITEMS / 4);
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d granted and %0d refused allocations, %0d frees",
               sb.allocs_ok, sb.allocs_failed, sb.frees);
      $display("idle phases: none, sender gaps, receiver stalls, both light");
      if (sb.grants_due.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.grants_due.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
